/* sv/cle_pkg.sv */
// shared types and codes for the circular list engine
package cle_pkg;

    localparam int VAL_W = 32;
    localparam int LEN_W = 7;
    localparam int POS_W = 7;

    typedef enum logic [2:0] {
        MD_INS_FRONT = 3'd0,
        MD_INS_END   = 3'd1,
        MD_INS_POS   = 3'd2,
        MD_DEL_FRONT = 3'd3,
        MD_DEL_REAR  = 3'd4,
        MD_DEL_VALUE = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef struct packed {
        logic [2:0]              mode;
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        position;
    } t_in_word;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [VAL_W-1:0] removed_value;
        logic [LEN_W-1:0]        length;
    } t_out_word;

    // controller to datapath
    typedef struct packed {
        logic latch;
        logic dispatch;
        logic walk;
        logic fix;
        logic load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic go_done;
        logic go_fix;
        logic walk_end;
        logic walk_ins;
        logic out_free;
    } t_sts;

endpackage

/* sv/cle_ctrl.sv */
// sequencer for the circular list engine
module cle_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  cle_pkg::t_sts i_sts,
    output cle_pkg::t_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_DISPATCH = 5'b00010,
        S_WALK     = 5'b00100,
        S_FIX      = 5'b01000,
        S_DONE     = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                o_cmd.dispatch = 1'b1;
                if (i_sts.go_done) begin
                    n_state = S_DONE;
                end else if (i_sts.go_fix) begin
                    n_state = S_FIX;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_sts.walk_end) begin
                    n_state = i_sts.walk_ins ? S_FIX : S_DONE;
                end
            end
            S_FIX: begin
                o_cmd.fix = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

/* sv/cle_dp.sv */
// list state, slot stores, link walker and result register
module cle_dp #(
    parameter int CAPACITY = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cle_pkg::t_in_word  i_in_data,
    input  cle_pkg::t_cmd      i_cmd,
    output cle_pkg::t_sts      o_sts,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output cle_pkg::t_out_word o_out_data
);

    localparam int SW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = cle_pkg::LEN_W + 1;
    localparam logic [CW-1:0] CNT_ONE = CW'(1);
    localparam logic [CW-1:0] CNT_CAP = CW'(CAPACITY);

    logic signed [cle_pkg::VAL_W-1:0] mem_val [CAPACITY];
    logic [SW-1:0]                    mem_link [CAPACITY];

    logic [2:0]                       r_mode;
    logic signed [cle_pkg::VAL_W-1:0] r_value;
    logic [cle_pkg::POS_W-1:0]        r_pos;
    cle_pkg::t_status                 r_status, n_status;
    logic signed [cle_pkg::VAL_W-1:0] r_removed, n_removed;
    logic [SW-1:0]                    r_first, n_first;
    logic [SW-1:0]                    r_last, n_last;
    logic [SW-1:0]                    r_cur, n_cur;
    logic [SW-1:0]                    r_prev, n_prev;
    logic [SW-1:0]                    r_slot, n_slot;
    logic [CW-1:0]                    r_count, n_count;
    logic [CW-1:0]                    r_steps, n_steps;
    logic [CAPACITY-1:0]              r_free, n_free;
    logic signed [cle_pkg::VAL_W-1:0] r_rd_val;
    logic [SW-1:0]                    r_rd_link;
    logic                             r_out_valid;
    cle_pkg::t_out_word               r_out_word;

    logic          is_ins, is_del, is_del_front, is_del_value;
    logic          is_full, is_empty, match, walk_end;
    logic          p_front, p_end;
    logic [PW-1:0] cnt_p1, pos_eff, p_eff;
    logic [SW-1:0] free_slot;
    logic          rd_en, vwe, lwe;
    logic [SW-1:0] rd_addr, lw_addr, lw_data;

    // lowest free slot: isolate the lowest set bit, then encode it
    function automatic logic [SW-1:0] low_free(input logic [CAPACITY-1:0] f);
        logic [CAPACITY-1:0] iso;
        logic [SW-1:0]       idx;
        iso = f & (~f + CAPACITY'(1));
        idx = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (iso[i]) begin
                idx = idx | SW'(i);
            end
        end
        return idx;
    endfunction

    always_comb begin
        is_ins       = 1'b0;
        is_del       = 1'b0;
        is_del_front = 1'b0;
        is_del_value = 1'b0;
        case (r_mode)
            cle_pkg::MD_INS_FRONT, cle_pkg::MD_INS_END, cle_pkg::MD_INS_POS: begin
                is_ins = 1'b1;
            end
            cle_pkg::MD_DEL_FRONT: begin
                is_del       = 1'b1;
                is_del_front = 1'b1;
            end
            cle_pkg::MD_DEL_REAR: begin
                is_del = 1'b1;
            end
            cle_pkg::MD_DEL_VALUE: begin
                is_del       = 1'b1;
                is_del_value = 1'b1;
            end
            default: begin
                is_ins = 1'b0;
            end
        endcase
    end

    // target position, clamped to length plus one
    always_comb begin
        cnt_p1  = PW'(r_count) + PW'(1);
        pos_eff = (r_pos == '0) ? PW'(1) : PW'(r_pos);
        case (r_mode)
            cle_pkg::MD_INS_FRONT: p_eff = PW'(1);
            cle_pkg::MD_INS_END:   p_eff = cnt_p1;
            default:               p_eff = (pos_eff > cnt_p1) ? cnt_p1 : pos_eff;
        endcase
        p_front = (p_eff == PW'(1));
        p_end   = !p_front && (p_eff == cnt_p1);
    end

    assign is_full   = (r_count == CNT_CAP);
    assign is_empty  = (r_count == '0);
    assign match     = (r_rd_val == r_value);
    assign walk_end  = (r_steps == '0) || (is_del_value && match);
    assign free_slot = low_free(r_free);

    always_comb begin
        n_status  = r_status;
        n_removed = r_removed;
        n_first   = r_first;
        n_last    = r_last;
        n_cur     = r_cur;
        n_prev    = r_prev;
        n_slot    = r_slot;
        n_count   = r_count;
        n_steps   = r_steps;
        n_free    = r_free;
        rd_en     = 1'b0;
        rd_addr   = r_first;
        vwe       = 1'b0;
        lwe       = 1'b0;
        lw_addr   = r_slot;
        lw_data   = r_first;

        if (i_cmd.latch) begin
            n_status  = cle_pkg::ST_OK;
            n_removed = '0;
        end

        if (i_cmd.dispatch) begin
            if (is_ins) begin
                if (is_full) begin
                    n_status = cle_pkg::ST_FULL;
                end else begin
                    vwe               = 1'b1;
                    n_slot            = free_slot;
                    n_free[free_slot] = 1'b0;
                    if (is_empty) begin
                        lwe     = 1'b1;
                        lw_addr = free_slot;
                        lw_data = free_slot;
                        n_first = free_slot;
                        n_last  = free_slot;
                        n_count = CW'(r_count + CNT_ONE);
                    end else if (p_front || p_end) begin
                        lwe     = 1'b1;
                        lw_addr = free_slot;
                        lw_data = r_first;
                        n_cur   = r_last;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = r_first;
                        n_steps = CW'(p_eff - PW'(2));
                    end
                end
            end else if (is_del) begin
                if (is_empty) begin
                    n_status = cle_pkg::ST_EMPTY;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_first;
                    n_prev  = r_last;
                    n_steps = is_del_front ? '0 : CW'(r_count - CNT_ONE);
                end
            end
        end

        if (i_cmd.walk) begin
            if (walk_end) begin
                if (is_ins) begin
                    lwe     = 1'b1;
                    lw_addr = r_slot;
                    lw_data = r_rd_link;
                end else if (is_del_value && !match) begin
                    n_status = cle_pkg::ST_NOTFOUND;
                end else begin
                    // unlink the entry under the walker
                    n_removed     = r_rd_val;
                    n_free[r_cur] = 1'b1;
                    if (r_count == CNT_ONE) begin
                        n_first = '0;
                        n_last  = '0;
                        n_count = '0;
                    end else begin
                        lwe     = 1'b1;
                        lw_addr = r_prev;
                        lw_data = r_rd_link;
                        if (r_cur == r_first) begin
                            n_first = r_rd_link;
                        end
                        if (r_cur == r_last) begin
                            n_last = r_prev;
                        end
                        n_count = CW'(r_count - CNT_ONE);
                    end
                end
            end else begin
                rd_en   = 1'b1;
                rd_addr = r_rd_link;
                n_prev  = r_cur;
                n_steps = CW'(r_steps - CNT_ONE);
            end
        end

        if (i_cmd.fix) begin
            lwe     = 1'b1;
            lw_addr = r_cur;
            lw_data = r_slot;
            if (p_front) begin
                n_first = r_slot;
            end else if (p_end) begin
                n_last = r_slot;
            end
            n_count = CW'(r_count + CNT_ONE);
        end

        if (rd_en) begin
            n_cur = rd_addr;
        end
    end

    // slot stores
    always_ff @(posedge i_clk) begin
        if (vwe) begin
            mem_val[free_slot] <= r_value;
        end
        if (lwe) begin
            mem_link[lw_addr] <= lw_data;
        end
        if (rd_en) begin
            r_rd_val  <= mem_val[rd_addr];
            r_rd_link <= mem_link[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_mode  <= i_in_data.mode;
            r_value <= i_in_data.value;
            r_pos   <= i_in_data.position;
        end
        r_status  <= n_status;
        r_removed <= n_removed;
        r_cur     <= n_cur;
        r_prev    <= n_prev;
        r_slot    <= n_slot;
        r_steps   <= n_steps;
        if (i_cmd.load) begin
            r_out_word.status        <= r_status;
            r_out_word.removed_value <= r_removed;
            r_out_word.length        <= cle_pkg::LEN_W'(r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first     <= '0;
            r_last      <= '0;
            r_count     <= '0;
            r_free      <= '1;
            r_out_valid <= 1'b0;
        end else begin
            r_first <= n_first;
            r_last  <= n_last;
            r_count <= n_count;
            r_free  <= n_free;
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.go_done  = !(is_ins || is_del) || (is_ins && (is_full || is_empty))
                            || (is_del && is_empty);
    assign o_sts.go_fix   = is_ins && !is_full && !is_empty && (p_front || p_end);
    assign o_sts.walk_end = walk_end;
    assign o_sts.walk_ins = is_ins;
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_word;

`ifndef SYNTH
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_CAP)
        else $error("entry count above capacity");

    a_free_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.latch |-> ($countones(r_free) + int'(r_count) == CAPACITY))
        else $error("free map and entry count disagree");

    a_empty_all_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.latch && r_count == '0) |-> (&r_free))
        else $error("empty list with allocated slots");

    a_walk_linked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.walk && !walk_end) |-> !r_free[r_rd_link])
        else $error("walker followed a link into a free slot");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> (!r_out_valid || !i_out_stall))
        else $error("result loaded over a word not yet taken");
`endif

endmodule

/* sv/circular_list_engine_top.sv */
// top level of the circular list engine: sequencer plus list datapath, one word at a time
// refusals, spare modes and inserts into an empty list go from dispatch to the result; front
// or end inserts add a link fix-up; front deletes unlink the first entry in the walk state;
// rear and value deletes walk the list, position inserts walk and then fix up; the walk reads
// one entry per cycle, single port; a finished result waits in its own register
// reset (synchronous, active low) empties the list and frees all slots, no clearing pass
module circular_list_engine_top #(
    parameter int CAPACITY = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input word channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  cle_pkg::t_in_word  i_in_data,
    // result word channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output cle_pkg::t_out_word o_out_data
);

    // command and status between sequencer and datapath
    cle_pkg::t_cmd cmd;
    cle_pkg::t_sts sts;

    // sequencer: idle, dispatch, link walk, link fix-up, result hand-off
    cle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath: value and link stores, free map, first/last/count, walker
    cle_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
